/* rtl/core/rbv_pkg.sv */
// Shared types, constants and the CRC-32C byte step for the record batch validator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rbv_pkg;

  // Header layout: byte positions where each little-endian field starts.
  localparam logic [31:0] POS_LEN   = 32'd8;
  localparam logic [31:0] POS_CRC   = 32'd12;
  localparam logic [31:0] POS_ATTR  = 32'd16;
  localparam logic [31:0] POS_PID   = 32'd18;
  localparam logic [31:0] POS_EPOCH = 32'd26;
  localparam logic [31:0] POS_SEQ   = 32'd28;
  localparam logic [31:0] POS_RC    = 32'd32;
  localparam logic [31:0] HDR_BYTES = 32'd36;
  localparam logic [31:0] HDR_LAST  = HDR_BYTES - 32'd1;

  // The batch total counts from the end of the length field.
  localparam logic [31:0] LEN_END   = POS_CRC;

  // Reflected CRC-32C.
  localparam logic [31:0] CRC_POLY  = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Decoupling queue between the front and back parts.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TRUNC   = 3'd1,
    ST_NEG_LEN = 3'd2,
    ST_BAD_LEN = 3'd3,
    ST_CRC     = 3'd4
  } status_t;

  // One queue entry: what a single input byte causes.
  typedef struct packed {
    logic        has_payload;
    logic [7:0]  payload_byte;
    logic        has_verdict;
    status_t     status;
    logic        hdr_valid;
    logic [63:0] batch_base;
    logic [15:0] attributes;
    logic [63:0] writer_id;
    logic [15:0] writer_epoch;
    logic [31:0] first_seq;
    logic [31:0] rec_count;
    logic [31:0] batch_size;
  } rbv_entry_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic valid;
    logic full;
  } rbv_qstat_t;

  // One byte of reflected CRC-32C, bit by bit.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rbv_front.sv */
// Front part: accepts bytes, parses the batch header, runs the CRC and classifies
// each byte into a queue entry. Depends on rbv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbv_front
  import rbv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_span,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  rbv_qstat_t q_stat,
  output logic       q_push,
  output rbv_entry_t q_entry
);

  // Span state.
  logic [31:0] byte_position;
  logic        verdict_done;
  logic [31:0] running_crc;
  logic        peek_mode;

  // Header field registers; every lane is written before it is used.
  logic [63:0] batch_base_reg;
  logic [31:0] length_reg;
  logic [31:0] header_crc_reg;
  logic [15:0] attributes_reg;
  logic [63:0] writer_id_reg;
  logic [15:0] writer_epoch_reg;
  logic [31:0] first_seq_reg;
  logic [31:0] rec_count_reg;

  logic [63:0] batch_base_next;
  logic [31:0] length_next;
  logic [31:0] header_crc_next;
  logic [15:0] attributes_next;
  logic [63:0] writer_id_next;
  logic [15:0] writer_epoch_next;
  logic [31:0] first_seq_next;
  logic [31:0] rec_count_next;
  logic [31:0] running_crc_next;

  logic [31:0] total;
  logic        crc_match;
  logic [2:0]  pid_lane;
  logic        accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign pid_lane = byte_position[2:0] - POS_PID[2:0];

  // Merge the incoming byte into the header field it belongs to.
  always_comb begin
    batch_base_next   = batch_base_reg;
    length_next       = length_reg;
    header_crc_next   = header_crc_reg;
    attributes_next   = attributes_reg;
    writer_id_next    = writer_id_reg;
    writer_epoch_next = writer_epoch_reg;
    first_seq_next    = first_seq_reg;
    rec_count_next    = rec_count_reg;
    if (byte_position < POS_LEN) begin
      batch_base_next[{byte_position[2:0], 3'b000} +: 8] = data_byte;
    end else if (byte_position < POS_CRC) begin
      length_next[{byte_position[1:0], 3'b000} +: 8] = data_byte;
    end else if (byte_position < POS_ATTR) begin
      header_crc_next[{byte_position[1:0], 3'b000} +: 8] = data_byte;
    end else if (byte_position < POS_PID) begin
      attributes_next[{byte_position[0], 3'b000} +: 8] = data_byte;
    end else if (byte_position < POS_EPOCH) begin
      writer_id_next[{pid_lane, 3'b000} +: 8] = data_byte;
    end else if (byte_position < POS_SEQ) begin
      writer_epoch_next[{byte_position[0], 3'b000} +: 8] = data_byte;
    end else if (byte_position < POS_RC) begin
      first_seq_next[{byte_position[1:0], 3'b000} +: 8] = data_byte;
    end else if (byte_position < HDR_BYTES) begin
      rec_count_next[{byte_position[1:0], 3'b000} +: 8] = data_byte;
    end
  end

  // CRC covers everything from the attributes field onward.
  always_comb begin
    running_crc_next = running_crc;
    if (byte_position >= POS_ATTR) begin
      running_crc_next = crc32c_byte(running_crc, data_byte);
    end
  end

  assign total     = LEN_END + {1'b0, length_next[30:0]};
  assign crc_match = ((running_crc_next ^ CRC_INIT) == header_crc_next);

  // Classify the byte into payload and verdict results.
  always_comb begin
    q_entry = '0;
    if (byte_position >= HDR_LAST) begin
      q_entry.hdr_valid    = 1'b1;
      q_entry.batch_base   = batch_base_next;
      q_entry.attributes   = attributes_next;
      q_entry.writer_id    = writer_id_next;
      q_entry.writer_epoch = writer_epoch_next;
      q_entry.first_seq    = first_seq_next;
      q_entry.rec_count    = rec_count_next;
      q_entry.batch_size   = total;
    end
    if (byte_position < HDR_LAST) begin
      q_entry.has_verdict = end_of_span;
      q_entry.status      = ST_TRUNC;
    end else if (byte_position == HDR_LAST) begin
      q_entry.has_verdict = 1'b1;
      if (length_next[31]) begin
        q_entry.status     = ST_NEG_LEN;
        q_entry.batch_size = '0;
      end else if (total < HDR_BYTES) begin
        q_entry.status = ST_BAD_LEN;
      end else if (peek_mode) begin
        q_entry.status = ST_OK;
      end else if (total == HDR_BYTES) begin
        q_entry.status = crc_match ? ST_OK : ST_CRC;
      end else begin
        q_entry.has_verdict = end_of_span;
        q_entry.status      = ST_BAD_LEN;
      end
    end else begin
      q_entry.has_payload  = 1'b1;
      q_entry.payload_byte = data_byte;
      if (byte_position == total - 32'd1) begin
        q_entry.has_verdict = 1'b1;
        q_entry.status      = crc_match ? ST_OK : ST_CRC;
      end else if (end_of_span) begin
        q_entry.has_verdict = 1'b1;
        q_entry.status      = ST_BAD_LEN;
      end
    end
  end

  assign q_push = accept && !verdict_done && (q_entry.has_payload || q_entry.has_verdict);

  // Span control state; the end of a span always restarts parsing.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      verdict_done  <= 1'b0;
      running_crc   <= CRC_INIT;
    end else if (accept) begin
      if (end_of_span) begin
        byte_position <= '0;
        verdict_done  <= 1'b0;
        running_crc   <= CRC_INIT;
      end else if (!verdict_done) begin
        byte_position <= byte_position + 32'd1;
        verdict_done  <= q_entry.has_verdict;
        running_crc   <= running_crc_next;
      end
    end
  end

  // Header field capture.
  always_ff @(posedge clk) begin
    if (accept && !verdict_done) begin
      batch_base_reg   <= batch_base_next;
      length_reg       <= length_next;
      header_crc_reg   <= header_crc_next;
      attributes_reg   <= attributes_next;
      writer_id_reg    <= writer_id_next;
      writer_epoch_reg <= writer_epoch_next;
      first_seq_reg    <= first_seq_next;
      rec_count_reg    <= rec_count_next;
    end
  end

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      peek_mode <= 1'b0;
    end else if (cfg_write) begin
      peek_mode <= cfg_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rbv_queue.sv */
// Short queue of classified entries between the front and back parts.
// Depends on rbv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbv_queue
  import rbv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rbv_entry_t push_entry,
  input  logic       pop,
  output rbv_qstat_t stat,
  output rbv_entry_t head
);

  rbv_entry_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign head       = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rbv_back.sv */
// Back part: turns queue entries into result transactions in an output register,
// payload before verdict. Depends on rbv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbv_back
  import rbv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  rbv_qstat_t         q_stat,
  input  rbv_entry_t         q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [7:0]         payload_byte,
  output logic [2:0]         status,
  output logic signed [63:0] batch_base,
  output logic [15:0]        attributes,
  output logic signed [63:0] writer_id,
  output logic signed [15:0] writer_epoch,
  output logic signed [31:0] first_seq,
  output logic signed [31:0] rec_count,
  output logic [31:0]        batch_size,
  output logic signed [63:0] final_offset,
  output logic               is_last
);

  // Set once the payload half of a two-result entry has gone out.
  logic        payload_sent;
  logic        load;
  logic        sel_payload;
  logic [63:0] final_offset_calc;

  assign load        = q_stat.valid && (!out_valid || out_ready);
  assign sel_payload = q_head.has_payload && !payload_sent;
  assign q_pop       = load && (!sel_payload || !q_head.has_verdict);

  assign final_offset_calc = q_head.hdr_valid
    ? (q_head.batch_base + {{32{q_head.rec_count[31]}}, q_head.rec_count} - 64'd1)
    : 64'd0;

  // Output valid and split tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      payload_sent <= 1'b0;
    end else begin
      if (load) begin
        out_valid    <= 1'b1;
        payload_sent <= sel_payload && q_head.has_verdict;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      if (sel_payload) begin
        kind         <= KIND_PAYLOAD;
        payload_byte <= q_head.payload_byte;
        status       <= ST_OK;
        batch_base   <= '0;
        attributes   <= '0;
        writer_id    <= '0;
        writer_epoch <= '0;
        first_seq    <= '0;
        rec_count    <= '0;
        batch_size   <= '0;
        final_offset <= '0;
        is_last      <= 1'b0;
      end else begin
        kind         <= KIND_VERDICT;
        payload_byte <= '0;
        status       <= q_head.status;
        batch_base   <= q_head.batch_base;
        attributes   <= q_head.attributes;
        writer_id    <= q_head.writer_id;
        writer_epoch <= q_head.writer_epoch;
        first_seq    <= q_head.first_seq;
        rec_count    <= q_head.rec_count;
        batch_size   <= q_head.batch_size;
        final_offset <= final_offset_calc;
        is_last      <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/record_batch_validator.sv */
// Record batch validator: header parse and CRC-32C check of one batch per span.
// Top level; instantiates rbv_front, rbv_queue and rbv_back, depends on rbv_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one byte per transaction, with
//   end_of_span on the last byte of a span. Output channel (out_valid/out_ready)
//   carries result transactions: record payload bytes (kind 0) in decode mode,
//   then one verdict (kind 1, is_last 1) per span with the parsed header fields.
//   peek_mode is written through cfg_write/cfg_data while the block is idle.
// Path: a byte is classified combinationally and its entry is written into the queue
//   at the edge that accepts it; the back loads the entry into the output register.
// Throughput: one byte per cycle while the queue has room. The byte that closes a
//   batch with a payload byte and a verdict yields two output transactions; the
//   two-entry queue between the classifying front and the output back absorbs that.
// Reset (rst, synchronous) empties the queue and output register, clears
//   peek_mode and starts a fresh span.
// When the receiver stalls, the output register holds, the queue fills and
//   in_ready drops once it is full; no transaction is lost.
`timescale 1ns / 1ps
`default_nettype none

module record_batch_validator
  import rbv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_span,
  input  logic               cfg_write,
  input  logic               cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [7:0]         payload_byte,
  output logic [2:0]         status,
  output logic signed [63:0] batch_base,
  output logic [15:0]        attributes,
  output logic signed [63:0] writer_id,
  output logic signed [15:0] writer_epoch,
  output logic signed [31:0] first_seq,
  output logic signed [31:0] rec_count,
  output logic [31:0]        batch_size,
  output logic signed [63:0] final_offset,
  output logic               is_last
);

  rbv_qstat_t q_stat;
  rbv_entry_t q_entry;
  rbv_entry_t q_head;
  logic       q_push;
  logic       q_pop;

  // Byte parsing and classification.
  rbv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .end_of_span (end_of_span),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  // Decoupling queue.
  rbv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .stat       (q_stat),
    .head       (q_head)
  );

  // Result sequencing and output register.
  rbv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .status       (status),
    .batch_base   (batch_base),
    .attributes   (attributes),
    .writer_id    (writer_id),
    .batch_size   (batch_size),
    .writer_epoch (writer_epoch),
    .first_seq    (first_seq),
    .rec_count    (rec_count),
    .final_offset (final_offset),
    .is_last      (is_last)
  );

  // Every queued entry carries at least one result.
  assert property (@(posedge clk) disable iff (rst)
    q_stat.valid |-> (q_head.has_payload || q_head.has_verdict))
    else $error("queue entry without any result");

  // Payload transactions carry status ok and never close a batch.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_PAYLOAD) |-> (status == ST_OK && !is_last))
    else $error("payload transaction with verdict markings");

  // A truncated-header verdict reports no size and no final offset.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_VERDICT && status == ST_TRUNC)
      |-> (batch_size == 32'd0 && final_offset == 64'sd0))
    else $error("truncated verdict with nonzero size fields");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for record_batch_validator: batch spans in, payload bytes and verdicts out.
// Holds its own header parser and CRC-32C predictor in a small scoreboard class.
// Depends on rbv_pkg and the record_batch_validator top level.
`timescale 1ns / 1ps

// One result transaction as seen on the output channel.
typedef struct {
  logic              kind;
  logic [7:0]        payload_byte;
  rbv_pkg::status_t  status;
  logic [63:0]       batch_base;
  logic [15:0]       attributes;
  logic [63:0]       writer_id;
  logic [15:0]       writer_epoch;
  logic [31:0]       first_seq;
  logic [31:0]       rec_count;
  logic [31:0]       batch_size;
  logic [63:0]       final_offset;
  logic              is_last;
} batch_result_t;

// Header fields used to build a span.
typedef struct {
  logic [63:0] base;
  logic [31:0] len;
  logic [15:0] attr;
  logic [63:0] pid;
  logic [15:0] epoch;
  logic [31:0] seq;
  logic [31:0] rc;
} batch_header_t;

// Reflected CRC-32C, one byte at a time.
function automatic logic [31:0] crc32c_next(logic [31:0] acc, logic [7:0] b);
  logic [31:0] c;
  int k;
  c = acc ^ {24'd0, b};
  for (k = 0; k < 8; k++) begin
    c = {1'b0, c[31:1]} ^ (c[0] ? rbv_pkg::CRC_POLY : 32'd0);
  end
  return c;
endfunction

// Predicts the results of every accepted byte and checks the block's results in order.
class batch_scoreboard;
  bit          peek_mode;
  logic [31:0] position;
  logic [63:0] base_reg;
  logic [31:0] length_reg;
  logic [31:0] header_crc;
  logic [15:0] attr_reg;
  logic [63:0] pid_reg;
  logic [15:0] epoch_reg;
  logic [31:0] seq_reg;
  logic [31:0] rc_reg;
  logic [31:0] crc_acc;
  bit          closed;

  batch_result_t results_due[$];
  int unsigned   mismatches;
  int unsigned   bytes_taken;
  int unsigned   spans_taken;
  int unsigned   payloads_seen;
  int unsigned   verdicts_by_status[5];

  function new();
    peek_mode = 1'b0;
    mismatches = 0;
    bytes_taken = 0;
    spans_taken = 0;
    payloads_seen = 0;
    foreach (verdicts_by_status[i]) verdicts_by_status[i] = 0;
    restart();
  endfunction

  // Every span starts with a clean header and a preset CRC.
  function void restart();
    position = 32'd0;
    base_reg = 64'd0;
    length_reg = 32'd0;
    header_crc = 32'd0;
    attr_reg = 16'd0;
    pid_reg = 64'd0;
    epoch_reg = 16'd0;
    seq_reg = 32'd0;
    rc_reg = 32'd0;
    crc_acc = rbv_pkg::CRC_INIT;
    closed = 1'b0;
  endfunction

  function batch_result_t blank_result();
    batch_result_t r;
    r.kind = rbv_pkg::KIND_PAYLOAD;
    r.payload_byte = 8'd0;
    r.status = rbv_pkg::ST_OK;
    r.batch_base = 64'd0;
    r.attributes = 16'd0;
    r.writer_id = 64'd0;
    r.writer_epoch = 16'd0;
    r.first_seq = 32'd0;
    r.rec_count = 32'd0;
    r.batch_size = 32'd0;
    r.final_offset = 64'd0;
    r.is_last = 1'b0;
    return r;
  endfunction

  // Little-endian placement of one header byte.
  function void absorb(int idx, logic [7:0] b);
    if (idx < 8) base_reg[8*idx +: 8] = b;
    else if (idx < 12) length_reg[8*(idx-8) +: 8] = b;
    else if (idx < 16) header_crc[8*(idx-12) +: 8] = b;
    else if (idx < 18) attr_reg[8*(idx-16) +: 8] = b;
    else if (idx < 26) pid_reg[8*(idx-18) +: 8] = b;
    else if (idx < 28) epoch_reg[8*(idx-26) +: 8] = b;
    else if (idx < 32) seq_reg[8*(idx-28) +: 8] = b;
    else rc_reg[8*(idx-32) +: 8] = b;
  endfunction

  function void push_payload(logic [7:0] b);
    batch_result_t r;
    r = blank_result();
    r.payload_byte = b;
    results_due.push_back(r);
    payloads_seen++;
  endfunction

  // A verdict closes the batch; later bytes of the span are ignored.
  function void push_verdict(rbv_pkg::status_t st, bit with_fields, logic [31:0] size);
    batch_result_t r;
    r = blank_result();
    r.kind = rbv_pkg::KIND_VERDICT;
    r.status = st;
    r.is_last = 1'b1;
    if (with_fields) begin
      r.batch_base = base_reg;
      r.attributes = attr_reg;
      r.writer_id = pid_reg;
      r.writer_epoch = epoch_reg;
      r.first_seq = seq_reg;
      r.rec_count = rc_reg;
      r.batch_size = size;
      r.final_offset = base_reg + {{32{rc_reg[31]}}, rc_reg} - 64'd1;
    end
    results_due.push_back(r);
    verdicts_by_status[int'(st)]++;
    closed = 1'b1;
  endfunction

  // Called for every accepted input transaction.
  function void take_byte(logic [7:0] b, logic eos);
    logic [31:0] pos;
    logic [31:0] total;
    rbv_pkg::status_t crc_verdict;
    bytes_taken++;
    if (!closed) begin
      pos = position;
      if (pos < rbv_pkg::HDR_BYTES) absorb(int'(pos), b);
      if (pos >= rbv_pkg::POS_ATTR) crc_acc = crc32c_next(crc_acc, b);
      total = rbv_pkg::LEN_END + {1'b0, length_reg[30:0]};
      crc_verdict = ((crc_acc ^ 32'hFFFF_FFFF) == header_crc) ? rbv_pkg::ST_OK : rbv_pkg::ST_CRC;
      if (pos < rbv_pkg::HDR_LAST) begin
        // Span ended inside the header.
        if (eos) push_verdict(rbv_pkg::ST_TRUNC, 1'b0, 32'd0);
      end else if (pos == rbv_pkg::HDR_LAST) begin
        // Header complete: checks in priority order.
        if (length_reg[31]) push_verdict(rbv_pkg::ST_NEG_LEN, 1'b1, 32'd0);
        else if (total < rbv_pkg::HDR_BYTES) push_verdict(rbv_pkg::ST_BAD_LEN, 1'b1, total);
        else if (peek_mode) push_verdict(rbv_pkg::ST_OK, 1'b1, total);
        else if (total == rbv_pkg::HDR_BYTES) push_verdict(crc_verdict, 1'b1, total);
        else if (eos) push_verdict(rbv_pkg::ST_BAD_LEN, 1'b1, total);
      end else begin
        // Record bytes are forwarded, then the verdict at the total or at an early end.
        push_payload(b);
        if (pos == total - 32'd1) push_verdict(crc_verdict, 1'b1, total);
        else if (eos) push_verdict(rbv_pkg::ST_BAD_LEN, 1'b1, total);
      end
      position = pos + 32'd1;
    end
    if (eos) begin
      spans_taken++;
      restart();
    end
  endfunction

  // Keep the log readable once things go badly wrong.
  function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      mismatches++;
      if (mismatches <= 100) $error("%s: expected %h, got %h", name, want, seen);
    end
  endfunction

  // Called for every accepted output transaction.
  function void check_result(batch_result_t got);
    batch_result_t want;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 100) begin
        $error("result with nothing expected: kind %0d payload %h status %0d",
               got.kind, got.payload_byte, got.status);
      end
      return;
    end
    want = results_due.pop_front();
    compare_field("kind", 64'(want.kind), 64'(got.kind));
    compare_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
    compare_field("status", 64'(want.status), 64'(got.status));
    compare_field("batch_base", want.batch_base, got.batch_base);
    compare_field("attributes", 64'(want.attributes), 64'(got.attributes));
    compare_field("writer_id", want.writer_id, got.writer_id);
    compare_field("writer_epoch", 64'(want.writer_epoch), 64'(got.writer_epoch));
    compare_field("first_seq", 64'(want.first_seq), 64'(got.first_seq));
    compare_field("rec_count", 64'(want.rec_count), 64'(got.rec_count));
    compare_field("batch_size", 64'(want.batch_size), 64'(got.batch_size));
    compare_field("final_offset", want.final_offset, got.final_offset);
    compare_field("is_last", 64'(want.is_last), 64'(got.is_last));
  endfunction
endclass

module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        end_of_span = 1'b0;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic signed [63:0] batch_base;
  logic [15:0] attributes;
  logic signed [63:0] writer_id;
  logic signed [15:0] writer_epoch;
  logic signed [31:0] first_seq;
  logic signed [31:0] rec_count;
  logic [31:0] batch_size;
  logic signed [63:0] final_offset;
  logic        is_last;

  batch_scoreboard sb = new();
  logic [7:0]  span_q[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  record_batch_validator i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_span  (end_of_span),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .status       (status),
    .batch_base   (batch_base),
    .attributes   (attributes),
    .writer_id    (writer_id),
    .writer_epoch (writer_epoch),
    .first_seq    (first_seq),
    .rec_count    (rec_count),
    .batch_size   (batch_size),
    .final_offset (final_offset),
    .is_last      (is_last)
  );

  always #1 clk = ~clk;

  // Output side: check every accepted result and stall at random.
  always @(posedge clk) begin : result_monitor
    batch_result_t got;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got.kind = kind;
      got.payload_byte = payload_byte;
      got.status = rbv_pkg::status_t'(status);
      got.batch_base = batch_base;
      got.attributes = attributes;
      got.writer_id = writer_id;
      got.writer_epoch = writer_epoch;
      got.first_seq = first_seq;
      got.rec_count = rec_count;
      got.batch_size = batch_size;
      got.final_offset = final_offset;
      got.is_last = is_last;
      sb.check_result(got);
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Run limit far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One input transaction; returns at the edge where it is accepted.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_span <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_byte(b, eos);
  endtask

  // Sends part of the span; the last byte of the queue carries end_of_span.
  task automatic send_span_range(input int first, input int last);
    int i;
    for (i = first; i <= last; i++) send_byte(span_q[i], i == span_q.size() - 1);
  endtask

  task automatic send_span();
    send_span_range(0, span_q.size() - 1);
  endtask

  // Waits until every expected result has come and the pipeline is empty.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.results_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.results_due.size() != 0) begin
      $error("%0d expected results never arrived", sb.results_due.size());
      sb.mismatches += sb.results_due.size();
      sb.results_due.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_peek(input bit value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.peek_mode = value;
  endtask

  // Builds header, record bytes and trailing bytes, with the CRC over bytes 16 to the total.
  task automatic compose_batch(input batch_header_t h, input int body_len, input bit crc_good,
                               input int tail_len);
    logic [31:0] crc;
    logic [31:0] total;
    int i;
    span_q.delete();
    for (i = 0; i < 8; i++) span_q.push_back(h.base[8*i +: 8]);
    for (i = 0; i < 4; i++) span_q.push_back(h.len[8*i +: 8]);
    for (i = 0; i < 4; i++) span_q.push_back(8'h00);
    for (i = 0; i < 2; i++) span_q.push_back(h.attr[8*i +: 8]);
    for (i = 0; i < 8; i++) span_q.push_back(h.pid[8*i +: 8]);
    for (i = 0; i < 2; i++) span_q.push_back(h.epoch[8*i +: 8]);
    for (i = 0; i < 4; i++) span_q.push_back(h.seq[8*i +: 8]);
    for (i = 0; i < 4; i++) span_q.push_back(h.rc[8*i +: 8]);
    for (i = 0; i < body_len + tail_len; i++) span_q.push_back(8'($urandom));
    total = 32'd12 + {1'b0, h.len[30:0]};
    crc = 32'hFFFF_FFFF;
    for (i = 16; i < span_q.size() && i < total; i++) crc = crc32c_next(crc, span_q[i]);
    crc = ~crc;
    if (!crc_good) crc = crc ^ (32'd1 << $urandom_range(31));
    for (i = 0; i < 4; i++) span_q[12+i] = crc[8*i +: 8];
  endtask

  task automatic cut_span(input int keep);
    while (span_q.size() > keep) span_q.delete(span_q.size() - 1);
  endtask

  function automatic batch_header_t random_header(input logic [31:0] len);
    batch_header_t h;
    h.base = {$urandom, $urandom};
    h.len = len;
    h.attr = 16'($urandom);
    h.pid = {$urandom, $urandom};
    h.epoch = 16'($urandom);
    h.seq = $urandom;
    h.rc = $urandom;
    return h;
  endfunction

  // Mostly well-formed batches with random content, the rest broken spans and noise.
  task automatic random_span();
    batch_header_t h;
    int pick;
    int body;
    int i;
    pick = $urandom_range(99);
    body = ($urandom_range(19) == 0) ? $urandom_range(200, 60) : $urandom_range(24);
    if (pick < 65) begin
      h = random_header(32'd24 + body);
      compose_batch(h, body, $urandom_range(9) != 0, ($urandom_range(3) == 0) ? $urandom_range(4) : 0);
    end else if (pick < 75) begin
      h = random_header(32'd24 + body);
      compose_batch(h, body, 1'b1, 0);
      cut_span($urandom_range(35, 1));
    end else if (pick < 83) begin
      body = $urandom_range(30, 1);
      h = random_header(32'd24 + body);
      compose_batch(h, body, 1'b1, 0);
      cut_span($urandom_range(35 + body, 36));
    end else if (pick < 89) begin
      h = random_header($urandom | 32'h8000_0000);
      compose_batch(h, 0, 1'b1, $urandom_range(5));
    end else if (pick < 94) begin
      h = random_header($urandom_range(23));
      compose_batch(h, 0, 1'b1, $urandom_range(5));
    end else begin
      span_q.delete();
      for (i = 0; i < int'($urandom_range(80, 1)); i++) span_q.push_back(8'($urandom));
    end
    send_span();
  endtask

  initial begin : stimulus
    batch_header_t h;
    int phase;
    int phase_start;
    bit peek_done;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 10;
    recv_idle_pct = 10;
    write_peek(1'b0);

    // Single byte span and a span one byte short of a header.
    span_q.delete();
    span_q.push_back(8'hFF);
    send_span();
    h = random_header(32'd28);
    compose_batch(h, 4, 1'b1, 0);
    cut_span(35);
    send_span();

    // Negative lengths with extreme header fields, trailing bytes ignored.
    h.base = 64'h7FFF_FFFF_FFFF_FFFF;
    h.len = 32'h8000_0000;
    h.attr = 16'hFFFF;
    h.pid = 64'h8000_0000_0000_0000;
    h.epoch = 16'h8000;
    h.seq = 32'h7FFF_FFFF;
    h.rc = 32'h8000_0000;
    compose_batch(h, 0, 1'b1, 3);
    send_span();
    h = '{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
          16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    compose_batch(h, 0, 1'b1, 0);
    send_span();

    // Totals below the header size.
    h = '{64'd0, 32'd0, 16'd0, 64'd0, 16'd0, 32'd0, 32'd0};
    compose_batch(h, 0, 1'b1, 0);
    send_span();
    h = random_header(32'd23);
    compose_batch(h, 0, 1'b1, 2);
    send_span();

    // Exact fit with no records: final offset wraps below the most negative base.
    h = random_header(32'd24);
    h.base = 64'h8000_0000_0000_0000;
    h.rc = 32'd0;
    compose_batch(h, 0, 1'b1, 0);
    send_span();
    h = random_header(32'd24);
    compose_batch(h, 0, 1'b0, 1);
    send_span();

    // Records forwarded, good and bad CRC, trailing bytes ignored.
    h = random_header(32'd29);
    compose_batch(h, 5, 1'b1, 4);
    send_span();
    h = random_header(32'd29);
    compose_batch(h, 5, 1'b0, 0);
    send_span();

    // Span ends before the total, after some records and right at the header end.
    h = random_header(32'd34);
    compose_batch(h, 10, 1'b1, 0);
    cut_span(40);
    send_span();
    h = random_header(32'd34);
    compose_batch(h, 10, 1'b1, 0);
    cut_span(36);
    send_span();

    // Peek mode: header checks only, largest length, negative and short lengths.
    drain_results();
    write_peek(1'b1);
    h = random_header(32'd30);
    compose_batch(h, 6, 1'b0, 0);
    send_span();
    h = random_header(32'h7FFF_FFFF);
    compose_batch(h, 4, 1'b1, 0);
    send_span();
    h = random_header(32'h8000_0001);
    compose_batch(h, 0, 1'b1, 0);
    send_span();
    h = random_header(32'd10);
    compose_batch(h, 0, 1'b1, 0);
    send_span();

    // Mode changed in the middle of a header: the value at the last header byte counts.
    h = random_header(32'd27);
    compose_batch(h, 3, 1'b1, 0);
    send_span_range(0, 19);
    drain_results();
    write_peek(1'b0);
    send_span_range(20, span_q.size() - 1);
    h = random_header(32'd27);
    compose_batch(h, 3, 1'b1, 0);
    send_span_range(0, 9);
    drain_results();
    write_peek(1'b1);
    send_span_range(10, span_q.size() - 1);
    drain_results();

    // Random spans under three idling profiles, each in decode then peek mode.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_results();
      write_peek(1'b0);
      phase_start = sb.bytes_taken;
      peek_done = 1'b0;
      while (sb.bytes_taken - phase_start < 400) begin
        if (!peek_done && sb.bytes_taken - phase_start >= 300) begin
          drain_results();
          write_peek(1'b1);
          peek_done = 1'b1;
        end else if ($urandom_range(19) == 0) begin
          // Sender holds off until the block has delivered everything.
          drain_results();
        end
        random_span();
      end
    end

    drain_results();
    $display("Run covered %0d bytes in %0d spans, decode and peek modes, three idling profiles.",
             sb.bytes_taken, sb.spans_taken);
    $display("Predicted %0d payload bytes; verdicts ok %0d, truncated %0d, negative %0d, length %0d, crc %0d.",
             sb.payloads_seen, sb.verdicts_by_status[0], sb.verdicts_by_status[1],
             sb.verdicts_by_status[2], sb.verdicts_by_status[3], sb.verdicts_by_status[4]);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/rbv_pkg.sv
rtl/core/rbv_front.sv
rtl/core/rbv_queue.sv
rtl/core/rbv_back.sv
rtl/core/record_batch_validator.sv
tb/testbench.sv
